>>> rtl/button_volume_controller_assert.svh
// Assertion macros used by the volume controller top level.
`ifndef BUTTON_VOLUME_CONTROLLER_ASSERT_SVH
`define BUTTON_VOLUME_CONTROLLER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define BVC_ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define BVC_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/bvc_pkg.sv
// Shared types and constants of the button volume controller.
`timescale 1ns / 1ps

package bvc_pkg;

   localparam int FUNC_W     = 2;
   localparam int STEP_W     = 6;
   localparam int ATT_W      = 8;
   localparam int TIMEOUT_W  = 11;
   localparam int LEVEL_W    = 3;
   localparam int PRESS_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [STEP_W-1:0]    STEP_SIZE_RESET   = 6'd20;
   localparam logic [ATT_W-1:0]     INITIAL_ATT_RESET = 8'd40;
   localparam logic [TIMEOUT_W-1:0] LED_TIMEOUT_RESET = 11'd1000;
   localparam logic [TIMEOUT_W-1:0] VOL_TIMEOUT_RESET = 11'd400;
   localparam logic [ATT_W-1:0]     MUTE_ATT_RESET    = ATT_W'(5 * STEP_SIZE_RESET);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_BUTTON = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_ENABLE = 2'd2
   } func_type;

   typedef enum logic [PRESS_W-1:0] {
      PRESS_IDLE = 2'd0,
      PRESS_DEC  = 2'd1,
      PRESS_INC  = 2'd2
   } press_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE   = 2'd0,
      CSR_INITIAL_ATT = 2'd1,
      CSR_LED_TIMEOUT = 2'd2,
      CSR_VOL_TIMEOUT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STEP_W-1:0]    step_size;
      logic [ATT_W-1:0]     initial_att;
      logic [TIMEOUT_W-1:0] led_timeout_ms;
      logic [TIMEOUT_W-1:0] vol_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              inc_pressed;
      logic              dec_pressed;
      logic              enable_value;
   } req_item_type;

   typedef struct packed {
      logic [ATT_W-1:0]   codec_att;
      logic               amp_on;
      logic [LEVEL_W-1:0] led_level;
      logic               beep;
      logic [PRESS_W-1:0] press_state;
   } rsp_item_type;

endpackage

>>> rtl/bvc_req_if.sv
// Request channel carrying button, tick and enable items.
`timescale 1ns / 1ps

interface bvc_req_if;
   import bvc_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic              inc_pressed;
   logic              dec_pressed;
   logic              enable_value;

   modport source (output valid, func, inc_pressed, dec_pressed, enable_value,
                   input ready);
   modport sink   (input valid, func, inc_pressed, dec_pressed, enable_value,
                   output ready);
endinterface

>>> rtl/bvc_rsp_if.sv
// Response channel carrying codec, amplifier and LED status items.
`timescale 1ns / 1ps

interface bvc_rsp_if;
   import bvc_pkg::*;

   logic               valid;
   logic               ready;
   logic [ATT_W-1:0]   codec_att;
   logic               amp_on;
   logic [LEVEL_W-1:0] led_level;
   logic               beep;
   logic [PRESS_W-1:0] press_state;

   modport source (output valid, codec_att, amp_on, led_level, beep, press_state,
                   input ready);
   modport sink   (input valid, codec_att, amp_on, led_level, beep, press_state,
                   output ready);
endinterface

>>> rtl/bvc_csr.sv
// Configuration registers of the volume controller.
`timescale 1ns / 1ps

module bvc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             write_en,
   input  logic [bvc_pkg::CSR_IDX_W-1:0]    index,
   input  logic [bvc_pkg::CSR_DATA_W-1:0]   wdata,
   output bvc_pkg::cfg_type                 cfg,
   output logic                             init_load
);
   import bvc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    init_load_ff;
   logic    init_load_in;

   // Decode the register write
   always_comb begin
      cfg_in       = cfg_ff;
      init_load_in = 1'b0;
      if (write_en) begin
         unique case (csr_index_type'(index))
            CSR_STEP_SIZE: begin
               cfg_in.step_size = wdata[STEP_W-1:0];
            end
            CSR_INITIAL_ATT: begin
               cfg_in.initial_att = wdata[ATT_W-1:0];
               init_load_in       = 1'b1;
            end
            CSR_LED_TIMEOUT: begin
               cfg_in.led_timeout_ms = wdata[TIMEOUT_W-1:0];
            end
            CSR_VOL_TIMEOUT: begin
               cfg_in.vol_delay_ms = wdata[TIMEOUT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold the register values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size      <= STEP_SIZE_RESET;
         cfg_ff.initial_att    <= INITIAL_ATT_RESET;
         cfg_ff.led_timeout_ms <= LED_TIMEOUT_RESET;
         cfg_ff.vol_delay_ms   <= VOL_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pulse the load once the new initial attenuation sits in its register
   always_ff @(posedge clock) begin
      if (reset) begin
         init_load_ff <= 1'b0;
      end else begin
         init_load_ff <= init_load_in;
      end
   end

   assign cfg       = cfg_ff;
   assign init_load = init_load_ff;

endmodule

>>> rtl/bvc_timer.sv
// Millisecond countdown timer with start and expiry.
`timescale 1ns / 1ps

module bvc_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            tick,
   input  logic [bvc_pkg::TIMEOUT_W-1:0]   timeout,
   output logic                            expire
);
   import bvc_pkg::*;

   logic [TIMEOUT_W-1:0] count_ff;
   logic [TIMEOUT_W-1:0] count_in;
   logic                 running_ff;
   logic                 running_in;

   // Expire on a tick when the count is down to one or less
   assign expire = tick && running_ff && (count_ff <= TIMEOUT_W'(1));

   // Load on start, count down on tick
   always_comb begin
      count_in   = count_ff;
      running_in = running_ff;
      if (start) begin
         count_in   = timeout;
         running_in = 1'b1;
      end else if (expire) begin
         count_in   = '0;
         running_in = 1'b0;
      end else if (tick && running_ff) begin
         count_in = count_ff - TIMEOUT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         running_ff <= running_in;
      end
   end

endmodule

>>> rtl/bvc_core.sv
// Press state machine, attenuation and amplifier state of the controller.
`timescale 1ns / 1ps

module bvc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  bvc_pkg::req_item_type   item,
   input  bvc_pkg::cfg_type        cfg,
   input  logic                    init_load,
   output bvc_pkg::rsp_item_type   result
);
   import bvc_pkg::*;

   localparam int WIDE_W = ATT_W + 1;

   press_type          press_ff, press_in;
   logic [ATT_W-1:0]   cur_att_ff, cur_att_in;
   logic [ATT_W-1:0]   codec_ff, codec_in;
   logic               amp_ff, amp_in;
   logic               enabled_ff, enabled_in;
   logic [LEVEL_W-1:0] led_ff, led_in;

   logic [WIDE_W-1:0]  step1, step2, step3, step4, step5;
   logic [ATT_W-1:0]   mute_att;
   logic [WIDE_W-1:0]  dec_sum;
   logic [ATT_W-1:0]   inc_att, dec_att, press_att;
   logic [WIDE_W-1:0]  press_wide;
   logic               press_up;
   logic               beep;
   logic               led_start, vol_start, tick;
   logic               led_expire, vol_expire;

   // Multiples of the step for the mute value and the bar thresholds
   assign step1    = WIDE_W'(cfg.step_size);
   assign step2    = step1 << 1;
   assign step3    = step2 + step1;
   assign step4    = step1 << 2;
   assign step5    = step4 + step1;
   assign mute_att = (step5 > WIDE_W'(255)) ? ATT_W'(255) : step5[ATT_W-1:0];

   // Step the attenuation down (increase volume) or up (decrease volume)
   assign inc_att = ({1'b0, cur_att_ff} >= step1) ? cur_att_ff - step1[ATT_W-1:0]
                                                 : cur_att_ff;
   assign dec_sum = {1'b0, cur_att_ff} + step1;
   always_comb begin
      dec_att = cur_att_ff;
      if (dec_sum < step5) begin
         dec_att = (dec_sum > WIDE_W'(255)) ? ATT_W'(255) : dec_sum[ATT_W-1:0];
      end
   end

   assign press_up   = item.inc_pressed;
   assign press_att  = press_up ? inc_att : dec_att;
   assign press_wide = {1'b0, press_att};

   bvc_timer u_led_timer (
      .clock   (clock),
      .reset   (reset),
      .start   (led_start),
      .tick    (tick),
      .timeout (cfg.led_timeout_ms),
      .expire  (led_expire)
   );

   bvc_timer u_vol_timer (
      .clock   (clock),
      .reset   (reset),
      .start   (vol_start),
      .tick    (tick),
      .timeout (cfg.vol_delay_ms),
      .expire  (vol_expire)
   );

   assign tick = fire && (func_type'(item.func) == FUNC_TICK);

   // Next state and result for one item
   always_comb begin
      press_in   = press_ff;
      cur_att_in = cur_att_ff;
      codec_in   = codec_ff;
      amp_in     = amp_ff;
      enabled_in = enabled_ff;
      led_in     = led_ff;
      beep       = 1'b0;
      led_start  = 1'b0;
      vol_start  = 1'b0;

      if (init_load) begin
         cur_att_in = cfg.initial_att;
      end

      if (fire) begin
         unique case (func_type'(item.func))
            FUNC_BUTTON: begin
               unique case (press_ff)
                  PRESS_IDLE: begin
                     if (item.inc_pressed || item.dec_pressed) begin
                        cur_att_in = press_att;
                        if (!enabled_ff) begin
                           codec_in = press_att;
                           amp_in   = 1'b1;
                        end
                        vol_start = 1'b1;
                        led_start = 1'b1;
                        beep      = 1'b1;
                        press_in  = press_up ? PRESS_INC : PRESS_DEC;
                        // Map attenuation to a bar level
                        if (press_wide >= step5) begin
                           led_in = LEVEL_W'(0);
                        end else if (press_wide >= step4) begin
                           led_in = LEVEL_W'(1);
                        end else if (press_wide >= step3) begin
                           led_in = LEVEL_W'(2);
                        end else if (press_wide >= step2) begin
                           led_in = LEVEL_W'(3);
                        end else if (press_wide >= step1) begin
                           led_in = LEVEL_W'(4);
                        end else begin
                           led_in = LEVEL_W'(5);
                        end
                     end
                  end
                  PRESS_DEC: begin
                     if (!item.dec_pressed) press_in = PRESS_IDLE;
                  end
                  PRESS_INC: begin
                     if (!item.inc_pressed) press_in = PRESS_IDLE;
                  end
                  default: begin
                     press_in = PRESS_IDLE;
                  end
               endcase
            end
            FUNC_TICK: begin
               if (led_expire) led_in = '0;
               if (vol_expire && !enabled_ff) begin
                  codec_in = mute_att;
                  amp_in   = 1'b0;
               end
            end
            FUNC_ENABLE: begin
               if (item.enable_value) begin
                  codec_in   = cur_att_ff;
                  amp_in     = 1'b1;
                  enabled_in = 1'b1;
               end else begin
                  enabled_in = 1'b0;
                  vol_start  = 1'b1;
               end
            end
            default: begin
               beep = 1'b0;
            end
         endcase
      end
   end

   // Press state register
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= PRESS_IDLE;
      end else begin
         press_ff <= press_in;
      end
   end

   // Attenuation, amplifier and LED registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_att_ff <= INITIAL_ATT_RESET;
         codec_ff   <= MUTE_ATT_RESET;
         amp_ff     <= 1'b0;
         enabled_ff <= 1'b0;
         led_ff     <= '0;
      end else begin
         cur_att_ff <= cur_att_in;
         codec_ff   <= codec_in;
         amp_ff     <= amp_in;
         enabled_ff <= enabled_in;
         led_ff     <= led_in;
      end
   end

   assign result.codec_att   = codec_in;
   assign result.amp_on      = amp_in;
   assign result.led_level   = led_in;
   assign result.beep        = beep;
   assign result.press_state = press_in;

endmodule

>>> rtl/button_volume_controller.sv
// Top level of the two-button volume controller.
`timescale 1ns / 1ps
`include "button_volume_controller_assert.svh"

// Takes one item per clock cycle while no result waits untaken: a button
// sample, a millisecond tick or an enable request, and returns exactly one
// result item for each. An accepted item sits in an input register, passes
// through the press state machine, attenuation and timer logic, and lands in
// the result register. The result register parts the channels: with a result
// waiting, one more item is still taken into the input register.
// Configuration writes through the csr port take effect on the next cycle and
// belong to idle periods; writing the initial attenuation also loads the
// current attenuation, through a registered load pulse.
module button_volume_controller (
   input  logic                             clock,
   input  logic                             reset,
   bvc_req_if.sink                          req_chan,
   bvc_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  logic [bvc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bvc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bvc_pkg::*;

   cfg_type      cfg;
   logic         init_load;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type result;
   logic         advance;
   logic         fire;
   logic         req_take;
   logic         beep_out;
   logic         press_held;

   // Stall the input register only while a result waits untaken
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   bvc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .write_en  (csr_write_en),
      .index     (csr_index),
      .wdata     (csr_wdata),
      .cfg       (cfg),
      .init_load (init_load)
   );

   bvc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .cfg       (cfg),
      .init_load (init_load),
      .result    (result)
   );

   // Input register: load on accept, drop when the item moves on
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func         <= req_chan.func;
         in_item_ff.inc_pressed  <= req_chan.inc_pressed;
         in_item_ff.dec_pressed  <= req_chan.dec_pressed;
         in_item_ff.enable_value <= req_chan.enable_value;
      end
   end

   // Result register: load a new item, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.codec_att   = rsp_ff.codec_att;
   assign rsp_chan.amp_on      = rsp_ff.amp_on;
   assign rsp_chan.led_level   = rsp_ff.led_level;
   assign rsp_chan.beep        = rsp_ff.beep;
   assign rsp_chan.press_state = rsp_ff.press_state;

   assign beep_out   = rsp_valid_ff && rsp_ff.beep;
   assign press_held = (rsp_ff.press_state != PRESS_IDLE);

   // Checks on the item flow and the press result
   `BVC_ASSERT_NEXT(a_take_loads, clock, reset, req_take, in_valid_ff, "accepted item lost")
   `BVC_ASSERT_NEXT(a_fire_result, clock, reset, fire, rsp_valid_ff, "result not registered")
   `BVC_ASSERT_HOLDS(a_beep_press, clock, reset, beep_out |-> press_held, "beep without press")

endmodule
